>>> hw/rtl/eewc_pkg.sv
// Shared types and constants of the EEPROM write controller.
package eewc_pkg;

   // Request and response field widths.
   localparam int ADDR_W   = 10;
   localparam int BYTE_W   = 8;
   localparam int TICKS_W  = 20;
   localparam int STALL_W  = 3;
   localparam int ADDR_SPAN = 1 << ADDR_W;

   // Configuration port.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_IDX_W  = 2;

   typedef logic [CSR_IDX_W-1:0] reg_idx_type;
   localparam reg_idx_type REG_HAS_MODE     = 2'd0;
   localparam reg_idx_type REG_ATOMIC_TICKS = 2'd1;
   localparam reg_idx_type REG_SPLIT_TICKS  = 2'd2;
   localparam reg_idx_type REG_LEGACY_TICKS = 2'd3;

   // Request operation codes.
   localparam logic OP_CTRL_WRITE = 1'b0;
   localparam logic OP_TICK       = 1'b1;

   // Control register bit positions.
   localparam int BIT_READ  = 0;
   localparam int BIT_WRITE = 1;
   localparam int BIT_ARM   = 2;
   localparam int MODE_LO   = 4;
   localparam int MODE_HI   = 5;

   // Programming modes.
   typedef logic [1:0] mode_type;
   localparam mode_type MODE_ATOMIC   = 2'd0;
   localparam mode_type MODE_ERASE    = 2'd1;
   localparam mode_type MODE_WRITE    = 2'd2;
   localparam mode_type MODE_RESERVED = 2'd3;

   // CPU halt lengths.
   localparam logic [STALL_W-1:0] STALL_NONE  = 3'd0;
   localparam logic [STALL_W-1:0] STALL_WRITE = 3'd2;
   localparam logic [STALL_W-1:0] STALL_READ  = 3'd4;

   localparam logic [BYTE_W-1:0] ERASED_BYTE = 8'hFF;

   // Configuration reset values.
   localparam logic [TICKS_W-1:0] ATOMIC_TICKS_RST = 20'd54400;
   localparam logic [TICKS_W-1:0] SPLIT_TICKS_RST  = 20'd28800;
   localparam logic [TICKS_W-1:0] LEGACY_TICKS_RST = 20'd136000;

endpackage

>>> hw/rtl/eewc_req_if.sv
// Request channel of the EEPROM write controller.
interface eewc_req_if;
   import eewc_pkg::*;

   logic              valid;
   logic              ready;
   logic              operation;
   logic [BYTE_W-1:0] control_value;
   logic [ADDR_W-1:0] address;
   logic [BYTE_W-1:0] write_data;

   modport source (output valid, operation, control_value, address, write_data,
                   input ready);
   modport sink (input valid, operation, control_value, address, write_data,
                 output ready);
endinterface

>>> hw/rtl/eewc_rsp_if.sv
// Response channel of the EEPROM write controller.
interface eewc_rsp_if;
   import eewc_pkg::*;

   logic               valid;
   logic               ready;
   logic [BYTE_W-1:0]  control_now;
   logic [BYTE_W-1:0]  read_data;
   logic               read_valid;
   logic               write_started;
   logic [STALL_W-1:0] stall_cycles;

   modport source (output valid, control_now, read_data, read_valid, write_started,
                   stall_cycles, input ready);
   modport sink (input valid, control_now, read_data, read_valid, write_started,
                 stall_cycles, output ready);
endinterface

>>> hw/rtl/eewc_ram.sv
// Generic single-port-write, registered-read RAM.
module eewc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> hw/rtl/eeprom_write_controller.sv
// Top level of the EEPROM write controller: control register, timers and byte store.
//
// The block models a byte EEPROM behind an 8-bit control register. Each request on
// req_port is either a CPU write of the control byte (with the address and data
// register values) or one clock tick. Every request produces exactly one response on
// rsp_port carrying the control register after the request, read data, read and
// write flags, and the number of CPU halt cycles.
//
// A tick request is accepted and its response is registered at the same edge. For a
// control write the store is read at acceptance and the write-back and response happen
// in the following cycle, from ST_EXEC; each control write reads the store memory once
// and writes it at most once.
//
// Responses sit in an output register. A new request is accepted while that
// register is empty or being drained in the same cycle, so a stalled receiver holds
// the block after at most one finished response.
//
// After reset the store is swept to 0xFF, one byte per cycle, over all of its
// STORE_BYTES addresses; no request is accepted during the sweep, while the APB
// configuration port works throughout it. Configuration is to be written
// only while no request is in flight.
module eeprom_write_controller #(
   parameter int STORE_BYTES      = 1024,
   parameter int ARM_WINDOW_TICKS = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   eewc_req_if.sink                             req_port,
   eewc_rsp_if.source                           rsp_port,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [eewc_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [eewc_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [eewc_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                 pready
);
   import eewc_pkg::*;

   localparam int AW   = $clog2(STORE_BYTES);
   localparam int ARMW = $clog2(ARM_WINDOW_TICKS + 1);
   // Largest quotient an incoming address can have against the store size.
   localparam int MAX_Q = (ADDR_SPAN - 1) / STORE_BYTES;

   typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_EXEC} state_type;

   // Sequencer and registered outputs.
   state_type           state_ff, state_in;
   logic [AW-1:0]       clr_ff, clr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]   rsp_ctrl_ff, rsp_ctrl_in;
   logic [BYTE_W-1:0]   rsp_rdata_ff, rsp_rdata_in;
   logic                rsp_rvalid_ff, rsp_rvalid_in;
   logic                rsp_wstart_ff, rsp_wstart_in;
   logic [STALL_W-1:0]  rsp_stall_ff, rsp_stall_in;

   // Architectural state.
   logic [BYTE_W-1:0]   ctrl_ff, ctrl_in;
   mode_type            mode_ff, mode_in;
   logic [TICKS_W-1:0]  countdown_ff, countdown_in;
   logic [ARMW-1:0]     arm_ff, arm_in;

   // Control write held between acceptance and execution.
   logic [BYTE_W-1:0]   item_ctrl_ff, item_ctrl_in;
   logic [AW-1:0]       item_idx_ff, item_idx_in;
   logic [BYTE_W-1:0]   item_data_ff, item_data_in;

   // Configuration registers.
   logic                has_mode_ff;
   logic [TICKS_W-1:0]  atomic_ticks_ff;
   logic [TICKS_W-1:0]  split_ticks_ff;
   logic [TICKS_W-1:0]  legacy_ticks_ff;

   // Store memory ports.
   logic                ram_wr_en;
   logic [AW-1:0]       ram_wr_addr;
   logic [BYTE_W-1:0]   ram_wr_data;
   logic                ram_rd_en;
   logic [BYTE_W-1:0]   ram_rd_data;

   logic                req_fire;
   logic                rsp_free;
   logic [ADDR_W-1:0]   addr_base;
   logic [AW-1:0]       req_idx;
   reg_idx_type         csr_idx;
   logic                csr_write;

   eewc_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (STORE_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (req_idx),
      .rd_data (ram_rd_data)
   );

   // The output register is free when empty or drained at this edge.
   assign rsp_free       = !rsp_valid_ff || rsp_port.ready;
   assign req_port.ready = (state_ff == ST_IDLE) && rsp_free;
   assign req_fire       = req_port.valid && req_port.ready;

   // The address wraps modulo the store size. The quotient is small, so the largest
   // multiple of the store size not above the address is found by parallel compares.
   always_comb begin
      addr_base = '0;
      for (int k = 1; k <= MAX_Q; k++) begin
         if (32'(req_port.address) >= k * STORE_BYTES) begin
            addr_base = ADDR_W'(k * STORE_BYTES);
         end
      end
   end

   assign req_idx   = AW'(req_port.address - addr_base);
   assign ram_rd_en = req_fire && (req_port.operation == OP_CTRL_WRITE);

   always_comb begin
      logic                new_we;
      logic                new_arm;
      logic                trigger;
      logic [BYTE_W-1:0]   next_ctrl;
      logic [BYTE_W-1:0]   prog_data;
      logic [TICKS_W-1:0]  ticks;

      state_in      = state_ff;
      clr_in        = clr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_port.ready;
      rsp_ctrl_in   = rsp_ctrl_ff;
      rsp_rdata_in  = rsp_rdata_ff;
      rsp_rvalid_in = rsp_rvalid_ff;
      rsp_wstart_in = rsp_wstart_ff;
      rsp_stall_in  = rsp_stall_ff;
      ctrl_in       = ctrl_ff;
      mode_in       = mode_ff;
      countdown_in  = countdown_ff;
      arm_in        = arm_ff;
      item_ctrl_in  = item_ctrl_ff;
      item_idx_in   = item_idx_ff;
      item_data_in  = item_data_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = item_idx_ff;
      ram_wr_data   = item_data_ff;

      new_we    = item_ctrl_ff[BIT_WRITE];
      new_arm   = item_ctrl_ff[BIT_ARM];
      trigger   = new_we && !ctrl_ff[BIT_WRITE] && ctrl_ff[BIT_ARM];
      next_ctrl = item_ctrl_ff;
      prog_data = item_data_ff;
      ticks     = atomic_ticks_ff;

      case (state_ff)
         ST_CLEAR: begin
            // Sweep the whole store to the erased value after reset.
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = ERASED_BYTE;
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == AW'(STORE_BYTES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (req_port.operation == OP_TICK) begin
                  // Both timers run down; each clears its bit as it expires.
                  next_ctrl = ctrl_ff;
                  if (arm_ff != '0) begin
                     arm_in = arm_ff - 1'b1;
                     if (arm_ff == ARMW'(1)) begin
                        next_ctrl[BIT_ARM] = 1'b0;
                     end
                  end
                  if (countdown_ff != '0) begin
                     countdown_in = countdown_ff - 1'b1;
                     if (countdown_ff == TICKS_W'(1)) begin
                        next_ctrl[BIT_WRITE] = 1'b0;
                     end
                  end
                  ctrl_in       = next_ctrl;
                  rsp_valid_in  = 1'b1;
                  rsp_ctrl_in   = next_ctrl;
                  rsp_rdata_in  = '0;
                  rsp_rvalid_in = 1'b0;
                  rsp_wstart_in = 1'b0;
                  rsp_stall_in  = STALL_NONE;
               end else begin
                  // Hold the control write while the store is read.
                  item_ctrl_in = req_port.control_value;
                  item_idx_in  = req_idx;
                  item_data_in = req_port.write_data;
                  state_in     = ST_EXEC;
               end
            end
         end
         ST_EXEC: begin
            // Read, write-enable and arm bits are owned by hardware; the write
            // enable bit keeps its current value unless a program starts.
            next_ctrl[BIT_READ]  = 1'b0;
            next_ctrl[BIT_WRITE] = ctrl_ff[BIT_WRITE];
            next_ctrl[BIT_ARM]   = 1'b0;
            rsp_rdata_in  = '0;
            rsp_rvalid_in = 1'b0;
            rsp_wstart_in = 1'b0;
            rsp_stall_in  = STALL_NONE;

            // The mode is latched and a read performed only when write enable
            // is not requested.
            if (!new_we) begin
               mode_in = item_ctrl_ff[MODE_HI:MODE_LO];
               if (item_ctrl_ff[BIT_READ]) begin
                  rsp_rdata_in  = ram_rd_data;
                  rsp_rvalid_in = 1'b1;
                  rsp_stall_in  = STALL_READ;
               end
            end

            if (has_mode_ff) begin
               case (mode_ff)
                  MODE_ERASE: begin
                     prog_data = ERASED_BYTE;
                     ticks     = split_ticks_ff;
                  end
                  MODE_WRITE: begin
                     ticks = split_ticks_ff;
                  end
                  default: begin
                     // Atomic and the reserved mode share the combined timing.
                     ticks = atomic_ticks_ff;
                  end
               endcase
            end else begin
               ticks = legacy_ticks_ff;
            end

            if (trigger) begin
               ram_wr_en            = 1'b1;
               ram_wr_data          = prog_data;
               countdown_in         = (ticks == '0) ? TICKS_W'(1) : ticks;
               arm_in               = '0;
               next_ctrl[BIT_WRITE] = 1'b1;
               rsp_wstart_in        = 1'b1;
               rsp_stall_in         = STALL_WRITE;
            end else if (new_arm) begin
               // A fresh arm starts the window; re-arming keeps it running.
               if (!ctrl_ff[BIT_ARM]) begin
                  arm_in = ARMW'(ARM_WINDOW_TICKS);
               end
               next_ctrl[BIT_ARM] = 1'b1;
            end else begin
               arm_in = '0;
            end

            ctrl_in      = next_ctrl;
            rsp_valid_in = 1'b1;
            rsp_ctrl_in  = next_ctrl;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         ctrl_ff      <= '0;
         mode_ff      <= MODE_ATOMIC;
         countdown_ff <= '0;
         arm_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         ctrl_ff      <= ctrl_in;
         mode_ff      <= mode_in;
         countdown_ff <= countdown_in;
         arm_ff       <= arm_in;
      end
      rsp_ctrl_ff   <= rsp_ctrl_in;
      rsp_rdata_ff  <= rsp_rdata_in;
      rsp_rvalid_ff <= rsp_rvalid_in;
      rsp_wstart_ff <= rsp_wstart_in;
      rsp_stall_ff  <= rsp_stall_in;
      item_ctrl_ff  <= item_ctrl_in;
      item_idx_ff   <= item_idx_in;
      item_data_ff  <= item_data_in;
   end

   assign rsp_port.valid         = rsp_valid_ff;
   assign rsp_port.control_now   = rsp_ctrl_ff;
   assign rsp_port.read_data     = rsp_rdata_ff;
   assign rsp_port.read_valid    = rsp_rvalid_ff;
   assign rsp_port.write_started = rsp_wstart_ff;
   assign rsp_port.stall_cycles  = rsp_stall_ff;

   // APB configuration port: zero wait states, word-aligned registers.
   assign pready    = 1'b1;
   assign csr_idx   = paddr[CSR_ADDR_W-1:CSR_ADDR_W-CSR_IDX_W];
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         has_mode_ff     <= 1'b1;
         atomic_ticks_ff <= ATOMIC_TICKS_RST;
         split_ticks_ff  <= SPLIT_TICKS_RST;
         legacy_ticks_ff <= LEGACY_TICKS_RST;
      end else if (csr_write) begin
         case (csr_idx)
            REG_HAS_MODE:     has_mode_ff     <= pwdata[0];
            REG_ATOMIC_TICKS: atomic_ticks_ff <= pwdata[TICKS_W-1:0];
            REG_SPLIT_TICKS:  split_ticks_ff  <= pwdata[TICKS_W-1:0];
            REG_LEGACY_TICKS: legacy_ticks_ff <= pwdata[TICKS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_HAS_MODE:     prdata = CSR_DATA_W'(has_mode_ff);
         REG_ATOMIC_TICKS: prdata = CSR_DATA_W'(atomic_ticks_ff);
         REG_SPLIT_TICKS:  prdata = CSR_DATA_W'(split_ticks_ff);
         REG_LEGACY_TICKS: prdata = CSR_DATA_W'(legacy_ticks_ff);
         default:          prdata = '0;
      endcase
   end

   function automatic logic trigger_check();
      return item_ctrl_ff[BIT_WRITE] && !ctrl_ff[BIT_WRITE] && ctrl_ff[BIT_ARM];
   endfunction

   // The write-enable bit is set exactly while a program countdown runs.
   assert property (@(posedge clock) disable iff (reset)
      (countdown_ff != '0) == ctrl_ff[BIT_WRITE])
      else $error("write enable bit and busy countdown disagree");

   // A running arm window always has the master enable bit set.
   assert property (@(posedge clock) disable iff (reset)
      (arm_ff != '0) |-> ctrl_ff[BIT_ARM])
      else $error("arm window running without master enable");

   // No request is taken while the store is being swept.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_port.ready)
      else $error("request accepted during store sweep");

   // A started program shows busy and the write stall in its response.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && trigger_check()) |=>
         (rsp_valid_ff && rsp_wstart_ff && rsp_ctrl_ff[BIT_WRITE] &&
          rsp_stall_ff == STALL_WRITE))
      else $error("program start response malformed");

endmodule
